@@ sv/point_rotation_about_center_top_macros.svh @@
// Assertion macros for the point rotation block and its checker.
// Included by the checker file; no other dependencies.
`ifndef POINT_ROTATION_ABOUT_CENTER_TOP_MACROS_SVH
`define POINT_ROTATION_ABOUT_CENTER_TOP_MACROS_SVH

// concurrent check, masked while reset is active
`define PRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define PRC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/prc_pkg.sv @@
// Shared types, widths and constants for the point rotation block.
// No dependencies; imported by every module of the block.
package prc_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int ANGLE_WIDTH     = 16;
    localparam int ROTATION_STAGES = 16;
    localparam int GUARD_BITS      = 8;
    localparam int ATAN_ENTRIES    = 24;
    localparam int TURN_W          = 32;
    localparam int CORDIC_STAGES   = (ROTATION_STAGES < ATAN_ENTRIES) ?
                                     ROTATION_STAGES : ATAN_ENTRIES;

    localparam logic [TURN_W-1:0] GAIN_Q32 = 32'h9B74EDA8;

    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = DIFF_W;
    localparam int PROD_W      = MAG_W + TURN_W;
    localparam int RND_SHIFT   = TURN_W - GUARD_BITS;
    localparam int SCALE_W     = PROD_W - RND_SHIFT;
    localparam int XY_W        = COORD_WIDTH + GUARD_BITS + 4;
    localparam int Z_W         = TURN_W + 2;
    localparam int ANGLE_SHIFT = TURN_W - ANGLE_WIDTH;
    localparam int FINE_W      = XY_W - GUARD_BITS;
    localparam int SUM_W       = FINE_W + 1;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // quadrant codes from the top two angle bits
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] prc_coord_t;

    typedef struct packed {
        prc_coord_t             pt_x;
        prc_coord_t             pt_y;
        prc_coord_t             ctr_x;
        prc_coord_t             ctr_y;
        logic [ANGLE_WIDTH-1:0] turn_angle;
        logic                   clockwise;
    } prc_req_t;

    typedef struct packed {
        prc_coord_t rot_x;
        prc_coord_t rot_y;
        logic       saturated;
    } prc_rsp_t;

    // offset magnitudes
    typedef struct packed {
        logic [MAG_W-1:0]       mag_x;
        logic [MAG_W-1:0]       mag_y;
        logic                   neg_x;
        logic                   neg_y;
        logic [ANGLE_WIDTH-1:0] angle;
        prc_coord_t             cx;
        prc_coord_t             cy;
    } prc_diff_t;

    // gain products
    typedef struct packed {
        logic [PROD_W-1:0]      prod_x;
        logic [PROD_W-1:0]      prod_y;
        logic                   neg_x;
        logic                   neg_y;
        logic [ANGLE_WIDTH-1:0] angle;
        prc_coord_t             cx;
        prc_coord_t             cy;
    } prc_prod_t;

    // rotator vector, residual angle and carried center
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        prc_coord_t             cx;
        prc_coord_t             cy;
    } prc_rot_t;

    // atan(2^-i) as a 32-bit fraction of a full turn
    function automatic logic [TURN_W-1:0] atan_turn(input int idx);
        logic [TURN_W-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/prc_cordic.sv @@
// Pipelined CORDIC rotator: one micro-rotation per register stage.
// Depends on prc_pkg (prc_rot_t, atan_turn, stage count).
module prc_cordic
    import prc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  prc_rot_t in_data,
    output logic     out_valid,
    output prc_rot_t out_data
);

    wire prc_rot_t stage_data  [0:CORDIC_STAGES];
    wire           stage_valid [0:CORDIC_STAGES];

    assign stage_data[0]  = in_data;
    assign stage_valid[0] = in_valid;

    for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_stage
        localparam logic signed [Z_W-1:0] ANG = signed'(Z_W'(atan_turn(gi)));

        prc_rot_t rot_reg;
        prc_rot_t rot_next;
        logic     valid_reg;

        always_comb
        begin
            prc_rot_t cur;
            logic signed [XY_W-1:0] xs;
            logic signed [XY_W-1:0] ys;
            cur      = stage_data[gi];
            xs       = cur.x >>> gi;
            ys       = cur.y >>> gi;
            rot_next = cur;
            if (!cur.z[Z_W-1])
            begin
                rot_next.x = cur.x - ys;
                rot_next.y = cur.y + xs;
                rot_next.z = cur.z - ANG;
            end
            else
            begin
                rot_next.x = cur.x + ys;
                rot_next.y = cur.y - xs;
                rot_next.z = cur.z + ANG;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= stage_valid[gi];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                rot_reg <= rot_next;
        end

        assign stage_data[gi+1]  = rot_reg;
        assign stage_valid[gi+1] = valid_reg;
    end

    assign out_valid = stage_valid[CORDIC_STAGES];
    assign out_data  = stage_data[CORDIC_STAGES];

endmodule

@@ sv/point_rotation_about_center_top.sv @@
// Top level of the point rotation block: gain prescale, quadrant turn,
// CORDIC pipeline, rounding, recentering and clipping.
// Depends on prc_pkg and prc_cordic.
//
//   port group  dir  payload    handshake
//   req         in   prc_req_t  req_valid / req_stall
//   rsp         out  prc_rsp_t  rsp_valid / rsp_stall
//
// One request per cycle while req_stall is low; the result passes diff, prod, rot,
// the one-micro-rotation-per-stage CORDIC pipeline and rsp registers.
// All stages advance together; they hold while rsp is valid and stalled.
// rst_n clears the valid bits only; no clearing pass.
module point_rotation_about_center_top
    import prc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  prc_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output prc_rsp_t rsp
);

    logic      en;
    prc_diff_t diff_reg, diff_next;
    logic      diff_valid_reg;
    prc_prod_t prod_reg, prod_next;
    logic      prod_valid_reg;
    prc_rot_t  rot_reg, rot_next;
    logic      rot_valid_reg;
    logic      cordic_valid;
    prc_rot_t  cordic_data;
    prc_rsp_t  rsp_reg, rsp_next;
    logic      rsp_valid_reg;

    assign en        = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !en;

    // center offsets split into sign and magnitude
    always_comb
    begin
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        dx = DIFF_W'(req.pt_x) - DIFF_W'(req.ctr_x);
        dy = DIFF_W'(req.pt_y) - DIFF_W'(req.ctr_y);
        diff_next.neg_x = dx[DIFF_W-1];
        diff_next.neg_y = dy[DIFF_W-1];
        diff_next.mag_x = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        diff_next.mag_y = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        diff_next.angle = req.clockwise ? (ANGLE_WIDTH'(0) - req.turn_angle)
                                        : req.turn_angle;
        diff_next.cx    = req.ctr_x;
        diff_next.cy    = req.ctr_y;
    end

    // gain prescale
    always_comb
    begin
        prod_next.prod_x = diff_reg.mag_x * GAIN_Q32;
        prod_next.prod_y = diff_reg.mag_y * GAIN_Q32;
        prod_next.neg_x  = diff_reg.neg_x;
        prod_next.neg_y  = diff_reg.neg_y;
        prod_next.angle  = diff_reg.angle;
        prod_next.cx     = diff_reg.cx;
        prod_next.cy     = diff_reg.cy;
    end

    // round to guard bits, restore sign, exact quarter turns
    always_comb
    begin
        logic [PROD_W-1:0]      px;
        logic [PROD_W-1:0]      py;
        logic signed [XY_W-1:0] sx;
        logic signed [XY_W-1:0] sy;
        px = prod_reg.prod_x + (PROD_W'(1) << (RND_SHIFT - 1));
        py = prod_reg.prod_y + (PROD_W'(1) << (RND_SHIFT - 1));
        sx = signed'(XY_W'(px[PROD_W-1:RND_SHIFT]));
        sy = signed'(XY_W'(py[PROD_W-1:RND_SHIFT]));
        if (prod_reg.neg_x)
            sx = -sx;
        if (prod_reg.neg_y)
            sy = -sy;
        unique case (prod_reg.angle[ANGLE_WIDTH-1 -: 2])
            QUAD_0:
            begin
                rot_next.x = sx;
                rot_next.y = sy;
            end
            QUAD_90:
            begin
                rot_next.x = -sy;
                rot_next.y = sx;
            end
            QUAD_180:
            begin
                rot_next.x = -sx;
                rot_next.y = -sy;
            end
            QUAD_270:
            begin
                rot_next.x = sy;
                rot_next.y = -sx;
            end
            default:
            begin
                rot_next.x = sx;
                rot_next.y = sy;
            end
        endcase
        rot_next.z  = signed'(Z_W'({prod_reg.angle[ANGLE_WIDTH-3:0],
                                    {ANGLE_SHIFT{1'b0}}}));
        rot_next.cx = prod_reg.cx;
        rot_next.cy = prod_reg.cy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            rot_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            diff_valid_reg <= req_valid;
            prod_valid_reg <= diff_valid_reg;
            rot_valid_reg  <= prod_valid_reg;
            rsp_valid_reg  <= cordic_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            rot_reg  <= rot_next;
            rsp_reg  <= rsp_next;
        end
    end

    prc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid_reg),
        .in_data   (rot_reg),
        .out_valid (cordic_valid),
        .out_data  (cordic_data)
    );

    // drop guard bits, add center back, clip
    always_comb
    begin
        logic signed [XY_W-1:0]  rx;
        logic signed [XY_W-1:0]  ry;
        logic signed [FINE_W-1:0] fx;
        logic signed [FINE_W-1:0] fy;
        logic signed [SUM_W-1:0] ox;
        logic signed [SUM_W-1:0] oy;
        logic                    hit;
        rx  = cordic_data.x + (XY_W'(1) << (GUARD_BITS - 1));
        ry  = cordic_data.y + (XY_W'(1) << (GUARD_BITS - 1));
        fx  = signed'(rx[XY_W-1:GUARD_BITS]);
        fy  = signed'(ry[XY_W-1:GUARD_BITS]);
        ox  = SUM_W'(fx) + SUM_W'(cordic_data.cx);
        oy  = SUM_W'(fy) + SUM_W'(cordic_data.cy);
        hit = 1'b0;
        if (ox > SUM_W'(COORD_MAX))
        begin
            rsp_next.rot_x = COORD_MAX;
            hit            = 1'b1;
        end
        else if (ox < SUM_W'(COORD_MIN))
        begin
            rsp_next.rot_x = COORD_MIN;
            hit            = 1'b1;
        end
        else
            rsp_next.rot_x = ox[COORD_WIDTH-1:0];
        if (oy > SUM_W'(COORD_MAX))
        begin
            rsp_next.rot_y = COORD_MAX;
            hit            = 1'b1;
        end
        else if (oy < SUM_W'(COORD_MIN))
        begin
            rsp_next.rot_y = COORD_MIN;
            hit            = 1'b1;
        end
        else
            rsp_next.rot_y = oy[COORD_WIDTH-1:0];
        rsp_next.saturated = hit;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ sv/prc_checker.sv @@
// Port-level checks for the point rotation block, bound to its top level.
// Depends on prc_pkg and point_rotation_about_center_top_macros.svh.
`include "point_rotation_about_center_top_macros.svh"

module prc_checker
    import prc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input prc_req_t req,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input prc_rsp_t rsp
);

    logic rsp_blocked;
    logic clip_seen;

    assign rsp_blocked = rsp_valid && rsp_stall;
    assign clip_seen   = (rsp.rot_x == COORD_MAX) || (rsp.rot_x == COORD_MIN) ||
                         (rsp.rot_y == COORD_MAX) || (rsp.rot_y == COORD_MIN);

    `PRC_ASSERT_RST(a_reset_empty, !rst_n |=> !rsp_valid, "rsp valid after reset edge")
    `PRC_ASSERT(a_stall_cause, req_stall |-> rsp_blocked, "req stalled without rsp blocked")
    `PRC_ASSERT(a_rsp_hold, rsp_blocked |=> (rsp_valid && $stable(rsp)), "stalled rsp changed")
    `PRC_ASSERT(a_sat_edge, (rsp_valid && rsp.saturated) |-> clip_seen, "saturated, no clip")
    `PRC_ASSERT(a_req_known, req_valid |-> !$isunknown(req), "request payload unknown")

endmodule

bind point_rotation_about_center_top prc_checker u_prc_checker (.*);

@@ bench/tb.sv @@
// Self-checking bench for point_rotation_about_center_top: directed and random requests,
// predicted results in a queue, random idling on req and random backpressure on rsp.
// Depends on prc_pkg and the RTL of the block.
module tb;
    import prc_pkg::*;

    localparam int PIPE_LATENCY = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 28;

    // atan(2^-i) as a 32-bit turn fraction, index 0 is the last entry
    localparam logic [23:0][31:0] ATAN_STEP = {
        32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608,
        32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886,
        32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245,
        32'd10679838, 32'd21354465, 32'd42667331, 32'd85004756,
        32'd167458907, 32'd316933406, 32'd536870912
    };

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    prc_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    prc_rsp_t rsp;

    prc_rsp_t rotated_q[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       hold_cycles = 0;
    bit       gaps_on = 0;
    bit       stall_random = 0;

    point_rotation_about_center_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint gain_prescale(longint d);
        longint    mag;
        bit [63:0] prod;
        mag  = (d < 0) ? -d : d;
        prod = 64'(mag) * 64'(GAIN_Q32);
        prod = (prod + (64'd1 << (TURN_W - GUARD_BITS - 1))) >> (TURN_W - GUARD_BITS);
        return (d < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic prc_rsp_t rotate_about_center(prc_req_t r);
        prc_rsp_t               res;
        logic [ANGLE_WIDTH-1:0] ang;
        longint                 x, y, z, t, xs, ys, cx, cy, hi, lo;
        ang = r.clockwise ? ANGLE_WIDTH'(-r.turn_angle) : r.turn_angle;
        cx  = longint'($signed(r.ctr_x));
        cy  = longint'($signed(r.ctr_y));
        x   = gain_prescale(longint'($signed(r.pt_x)) - cx);
        y   = gain_prescale(longint'($signed(r.pt_y)) - cy);
        case (ang[ANGLE_WIDTH-1 -: 2])
            QUAD_90:
            begin
                t = x;
                x = -y;
                y = t;
            end
            QUAD_180:
            begin
                x = -x;
                y = -y;
            end
            QUAD_270:
            begin
                t = x;
                x = y;
                y = -t;
            end
            default:
            begin
            end
        endcase
        z = longint'(ang[ANGLE_WIDTH-3:0]) << (TURN_W - ANGLE_WIDTH);
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_STEP[i]);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_STEP[i]);
            end
        end
        x  = ((x + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS) + cx;
        y  = ((y + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS) + cy;
        hi = longint'(COORD_MAX);
        lo = longint'(COORD_MIN);
        res.saturated = 1'b0;
        if (x > hi)
        begin
            x = hi;
            res.saturated = 1'b1;
        end
        if (x < lo)
        begin
            x = lo;
            res.saturated = 1'b1;
        end
        if (y > hi)
        begin
            y = hi;
            res.saturated = 1'b1;
        end
        if (y < lo)
        begin
            y = lo;
            res.saturated = 1'b1;
        end
        res.rot_x = prc_coord_t'(x);
        res.rot_y = prc_coord_t'(y);
        return res;
    endfunction

    function automatic prc_req_t make_request(prc_coord_t px, prc_coord_t py, prc_coord_t cx,
                                              prc_coord_t cy, logic [ANGLE_WIDTH-1:0] ang,
                                              logic cw);
        prc_req_t r;
        r.pt_x       = px;
        r.pt_y       = py;
        r.ctr_x      = cx;
        r.ctr_y      = cy;
        r.turn_angle = ang;
        r.clockwise  = cw;
        return r;
    endfunction

    function automatic prc_coord_t random_coord();
        case ($urandom_range(9)) inside
            0:       return COORD_MAX - prc_coord_t'($urandom_range(255));
            1:       return COORD_MIN + prc_coord_t'($urandom_range(255));
            [2:3]:   return prc_coord_t'(int'($urandom_range(8191)) - 4096);
            default: return prc_coord_t'($urandom);
        endcase
    endfunction

    function automatic prc_req_t random_request();
        prc_req_t r;
        r.ctr_x = random_coord();
        r.ctr_y = random_coord();
        if ($urandom_range(1))
        begin
            // small offset around the center keeps most results in range
            r.pt_x = r.ctr_x + prc_coord_t'(int'($urandom_range(131071)) - 65536);
            r.pt_y = r.ctr_y + prc_coord_t'(int'($urandom_range(131071)) - 65536);
        end
        else
        begin
            r.pt_x = random_coord();
            r.pt_y = random_coord();
        end
        r.turn_angle = ANGLE_WIDTH'($urandom);
        r.clockwise  = 1'($urandom);
        return r;
    endfunction

    task automatic send_request(prc_req_t r);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        rotated_q.push_back(rotate_about_center(r));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(make_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 16'h0000, 1'b0));
        send_request(make_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'h8000, 1'b0));
        send_request(make_request(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 16'hFFFF, 1'b1));
        send_request(make_request(24'sd1234, -24'sd777, 24'sd1234, -24'sd777, 16'h2345, 1'b0));
        send_request(make_request(24'sd256, 24'sd0, 24'sd0, 24'sd0, 16'h4000, 1'b0));
        send_request(make_request(24'sd256, 24'sd0, 24'sd0, 24'sd0, 16'h4000, 1'b1));
        send_request(make_request(24'sd256, 24'sd0, 24'sd0, 24'sd0, 16'h8000, 1'b0));
        send_request(make_request(24'sd256, 24'sd0, 24'sd0, 24'sd0, 16'h8000, 1'b1));
        send_request(make_request(24'sd256, 24'sd0, 24'sd0, 24'sd0, 16'hC000, 1'b0));
        send_request(make_request(24'sd256, 24'sd0, 24'sd0, 24'sd0, 16'hC000, 1'b1));
        send_request(make_request(24'sd256, 24'sd256, 24'sd0, 24'sd0, 16'h0001, 1'b0));
        send_request(make_request(24'sd256, 24'sd256, 24'sd0, 24'sd0, 16'h3FFF, 1'b1));
        send_request(make_request(24'sd256, 24'sd256, 24'sd0, 24'sd0, 16'hFFFF, 1'b0));
        send_request(make_request(-24'sd1, -24'sd1, 24'sd0, 24'sd0, 16'h1234, 1'b0));
        send_request(make_request(24'sd1, 24'sd0, 24'sd0, 24'sd0, 16'h2000, 1'b1));
        send_request(make_request(COORD_MAX, COORD_MAX, 24'sd0, 24'sd0, 16'h2000, 1'b0));
        send_request(make_request(COORD_MIN, COORD_MIN, 24'sd0, 24'sd0, 16'h8000, 1'b0));
        send_request(make_request(COORD_MIN, 24'sd0, 24'sd0, 24'sd0, 16'h4000, 1'b1));
        send_request(make_request(COORD_MAX, 24'sd0, COORD_MAX, 24'sd0, 16'h6000, 1'b0));
        send_request(make_request(24'sd1000, 24'sd2000, -24'sd3000, 24'sd500, 16'hA5A5, 1'b1));
    endtask

    task automatic test_random_stream(int count);
        for (int n = 0; n < count; n++)
            send_request(random_request());
    endtask

    task automatic test_backpressure();
        gaps_on      = 1'b0;
        stall_random = 1'b0;
        hold_cycles  = 150;
        test_random_stream(60);
        gaps_on      = 1'b1;
        stall_random = 1'b1;
    endtask

    task automatic test_pause_until_empty();
        wait_for_results();
        test_random_stream(20);
    endtask

    task automatic test_no_idle_stretch();
        gaps_on      = 1'b0;
        stall_random = 1'b0;
        test_random_stream(100);
        gaps_on      = 1'b1;
        stall_random = 1'b1;
    endtask

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                rsp_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else if (stall_random)
                rsp_stall <= ($urandom_range(99) < IDLE_PCT);
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        prc_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rotated_q.size() == 0)
            begin
                $error("response with no request outstanding");
                error_count++;
            end
            else
            begin
                want = rotated_q.pop_front();
                if (rsp.rot_x !== want.rot_x)
                begin
                    $error("rot_x expected %0d actual %0d", want.rot_x, rsp.rot_x);
                    error_count++;
                end
                if (rsp.rot_y !== want.rot_y)
                begin
                    $error("rot_y expected %0d actual %0d", want.rot_y, rsp.rot_y);
                    error_count++;
                end
                if (rsp.saturated !== want.saturated)
                begin
                    $error("saturated expected %0b actual %0b", want.saturated, rsp.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        gaps_on      = 1'b1;
        stall_random = 1'b1;
        test_directed();
        test_random_stream(300);
        test_no_idle_stretch();
        test_backpressure();
        test_pause_until_empty();
        test_random_stream(220);

        wait_for_results();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
